@@ design/vmieu_pkg.sv @@
// Package of the integer execute unit: widths, command and condition codes,
// iteration control types and operand helpers. No dependencies.
`timescale 1ns / 1ps
package vmieu_pkg;

    localparam int REG_BITS      = 64;
    localparam int REG_COUNT_DEF = 256;
    localparam int CMD_W         = 5;
    localparam int WC_W          = 2;
    localparam int COND_W        = 3;
    localparam int RIDX_W        = 8;
    localparam int CNT_W         = 7;

    localparam logic [CMD_W-1:0] CMD_MOV   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_CMOV  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_CMP   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_TEST  = 5'd3;
    localparam logic [CMD_W-1:0] CMD_SET   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_LNOT  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_BNOT  = 5'd6;
    localparam logic [CMD_W-1:0] CMD_NEG   = 5'd7;
    localparam logic [CMD_W-1:0] CMD_ADD   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_SUB   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MUL   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_DIV   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_REM   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_SHL   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_LSHR  = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ASHR  = 5'd15;
    localparam logic [CMD_W-1:0] CMD_AND   = 5'd16;
    localparam logic [CMD_W-1:0] CMD_OR    = 5'd17;
    localparam logic [CMD_W-1:0] CMD_XOR   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SEXT1 = 5'd19;
    localparam logic [CMD_W-1:0] CMD_SEXT  = 5'd20;

    localparam logic [COND_W-1:0] COND_ALWAYS = 3'd0;
    localparam logic [COND_W-1:0] COND_EQ     = 3'd1;
    localparam logic [COND_W-1:0] COND_NE     = 3'd2;
    localparam logic [COND_W-1:0] COND_LT     = 3'd3;
    localparam logic [COND_W-1:0] COND_LE     = 3'd4;
    localparam logic [COND_W-1:0] COND_GT     = 3'd5;
    localparam logic [COND_W-1:0] COND_GE     = 3'd6;

    localparam logic [WC_W-1:0] WC_8  = 2'd0;
    localparam logic [WC_W-1:0] WC_16 = 2'd1;
    localparam logic [WC_W-1:0] WC_32 = 2'd2;
    localparam logic [WC_W-1:0] WC_64 = 2'd3;

    typedef logic [REG_BITS-1:0] t_word;

    typedef struct packed {
        logic start;
        logic is_div;
        logic wide;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

    function automatic t_word f_mask(input logic [WC_W-1:0] wc);
        t_word m;
        unique case (wc)
            WC_8:    m = 64'h0000_0000_0000_00ff;
            WC_16:   m = 64'h0000_0000_0000_ffff;
            WC_32:   m = 64'h0000_0000_ffff_ffff;
            default: m = 64'hffff_ffff_ffff_ffff;
        endcase
        return m;
    endfunction

    function automatic t_word f_sext(input t_word v, input logic [WC_W-1:0] wc);
        t_word r;
        unique case (wc)
            WC_8:    r = {{56{v[7]}}, v[7:0]};
            WC_16:   r = {{48{v[15]}}, v[15:0]};
            WC_32:   r = {{32{v[31]}}, v[31:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

@@ design/vmieu_if.sv @@
// Handshake interfaces of the integer execute unit: instruction and result items.
// Depends on vmieu_pkg.
`timescale 1ns / 1ps
interface vmieu_cmd_if;
    import vmieu_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [WC_W-1:0]     width_code;
    logic                is_signed;
    logic                use_immediate;
    logic [COND_W-1:0]   condition;
    logic [RIDX_W-1:0]   dest_reg;
    logic [RIDX_W-1:0]   src_reg;
    logic [REG_BITS-1:0] immediate;

    modport source (output valid, command, width_code, is_signed, use_immediate,
                    condition, dest_reg, src_reg, immediate, input ready);
    modport sink (input valid, command, width_code, is_signed, use_immediate,
                  condition, dest_reg, src_reg, immediate, output ready);
endinterface

interface vmieu_res_if;
    import vmieu_pkg::*;
    logic                valid;
    logic                ready;
    logic                wrote_reg;
    logic [RIDX_W-1:0]   written_reg;
    logic [REG_BITS-1:0] written_value;
    logic                less_flag;
    logic                equal_flag;
    logic                divide_by_zero;

    modport source (output valid, wrote_reg, written_reg, written_value, less_flag,
                    equal_flag, divide_by_zero, input ready);
    modport sink (input valid, wrote_reg, written_reg, written_value, less_flag,
                  equal_flag, divide_by_zero, output ready);
endinterface

@@ design/vmieu_iter.sv @@
// Shared shift-add multiplier and restoring divider, one bit a cycle.
// Depends on vmieu_pkg.
`timescale 1ns / 1ps
module vmieu_iter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vmieu_pkg::t_iter_ctl          i_ctl,
    input  logic [vmieu_pkg::REG_BITS-1:0] i_x,
    input  logic [vmieu_pkg::REG_BITS-1:0] i_y,
    output vmieu_pkg::t_iter_sts          o_sts,
    output logic [vmieu_pkg::REG_BITS-1:0] o_lo,
    output logic [vmieu_pkg::REG_BITS-1:0] o_rem
);
    import vmieu_pkg::*;

    logic             r_busy, r_done, r_div;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_x, r_y, r_acc, r_rem;
    logic [REG_BITS:0]   w_t, w_opa, w_opb;
    logic [REG_BITS+1:0] w_sum;
    logic             w_ge;

    always_comb begin
        w_t   = {r_rem, r_x[REG_BITS-1]};
        w_opa = r_div ? w_t : {1'b0, r_acc};
        w_opb = r_div ? ~{1'b0, r_y} : {1'b0, r_x};
        w_sum = {1'b0, w_opa} + {1'b0, w_opb} + (REG_BITS+2)'(r_div);
        w_ge  = w_sum[REG_BITS+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div <= i_ctl.is_div;
            r_cnt <= i_ctl.wide ? CNT_W'(64) : CNT_W'(32);
            r_x   <= (i_ctl.is_div && !i_ctl.wide) ? {i_x[31:0], 32'd0} : i_x;
            r_y   <= i_y;
            r_acc <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_x   <= {r_x[REG_BITS-2:0], 1'b0};
            if (r_div) begin
                r_acc <= {r_acc[REG_BITS-2:0], w_ge};
                r_rem <= w_ge ? w_sum[REG_BITS-1:0] : w_t[REG_BITS-1:0];
            end else begin
                r_y <= {1'b0, r_y[REG_BITS-1:1]};
                if (r_y[0]) begin
                    r_acc <= w_sum[REG_BITS-1:0];
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_lo       = r_acc;
    assign o_rem      = r_rem;
endmodule

@@ design/vm_integer_execute_unit_top.sv @@
// Integer execute unit: register file, flags, sequencer and shared mul/div unit.
// Depends on vmieu_pkg, vmieu_if and vmieu_iter.
// Sequence: an accepted item passes the read A, read B, execute and done states;
// mul, and div and rem by a nonzero divisor, add the iterate and post states.
// One item at a time: ready only in idle, and done waits until the output is free.
// Reset: synchronous active low; clears flags, register valid bits (all read as zero).
`timescale 1ns / 1ps
module vm_integer_execute_unit_top #(
    parameter int REG_COUNT = vmieu_pkg::REG_COUNT_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    vmieu_cmd_if.sink   i_cmd,
    vmieu_res_if.source o_res
);
    import vmieu_pkg::*;

    localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RDA  = 7'b0000010,
        S_RDB  = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_ITER = 7'b0010000,
        S_POST = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;

    logic [IDX_W-1:0] w_idx_tab [256];
    for (genvar k = 0; k < 256; k++) begin : g_idx
        assign w_idx_tab[k] = IDX_W'(k % REG_COUNT);
    end

    t_word          r_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_vld;
    t_word          r_rd;
    logic           r_rdv;
    logic [IDX_W-1:0] w_rd_addr;

    logic [CMD_W-1:0]  r_cmd;
    logic [WC_W-1:0]   r_wc, r_wce;
    logic              r_sgn, r_use_imm;
    logic [COND_W-1:0] r_cond;
    logic [IDX_W-1:0]  r_d, r_s;
    t_word             r_imm, r_a, r_b, r_res;
    logic              r_we, r_dz, r_less, r_equal, r_xn, r_qneg;

    logic              r_o_valid, r_o_we, r_o_less, r_o_equal, r_o_dz;
    logic [RIDX_W-1:0] r_o_reg;
    t_word             r_o_val;

    t_word     w_m, w_ca, w_cb, w_x, w_y, w_xs, w_ys, w_ux, w_uy, w_post, w_lo, w_rem;
    t_word     n_res;
    logic      n_we, n_dz, n_less, n_equal, n_xn, n_qneg, w_cond, w_iter, w_out_free;
    logic [5:0] w_sh;
    t_iter_ctl w_ctl;
    t_iter_sts w_sts;

    always_comb begin
        w_rd_addr = (r_state == S_IDLE) ? w_idx_tab[i_cmd.dest_reg] : r_s;
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= r_mem[w_rd_addr];
        r_rdv <= r_vld[w_rd_addr];
        if (r_state == S_DONE && w_out_free && r_we) begin
            r_mem[r_d] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (r_state == S_DONE && w_out_free && r_we) begin
            r_vld[r_d] <= 1'b1;
        end
    end

    always_comb begin
        unique case (r_cond)
            COND_ALWAYS: w_cond = 1'b1;
            COND_EQ:     w_cond = r_equal;
            COND_NE:     w_cond = !r_equal;
            COND_LT:     w_cond = r_less;
            COND_LE:     w_cond = r_less || r_equal;
            COND_GT:     w_cond = !r_less && !r_equal;
            COND_GE:     w_cond = !r_less;
            default:     w_cond = 1'b0;
        endcase
    end

    always_comb begin
        w_m  = f_mask(r_wce);
        w_sh = r_b[5:0] & {r_wce == WC_64, 5'h1f};
        w_x  = r_a & w_m;
        w_y  = r_b & w_m;
        w_xs = f_sext(r_a, r_wce);
        w_ys = f_sext(r_b, r_wce);
        n_xn = r_sgn && w_xs[REG_BITS-1];
        n_qneg = r_sgn && (w_xs[REG_BITS-1] != w_ys[REG_BITS-1]);
        w_ux = n_xn ? (t_word'(0) - w_xs) : w_x;
        w_uy = (r_sgn && w_ys[REG_BITS-1]) ? (t_word'(0) - w_ys) : w_y;
        if (r_sgn) begin
            w_ca = w_xs ^ {1'b1, {(REG_BITS-1){1'b0}}};
            w_cb = ((r_cmd == CMD_TEST) ? t_word'(0) : w_ys)
                   ^ {1'b1, {(REG_BITS-1){1'b0}}};
        end else begin
            w_ca = w_x;
            w_cb = (r_cmd == CMD_TEST) ? t_word'(0) : w_y;
        end

        n_res   = '0;
        n_we    = 1'b1;
        n_dz    = 1'b0;
        n_less  = r_less;
        n_equal = r_equal;
        w_iter  = 1'b0;
        unique case (r_cmd)
            CMD_MOV:   n_res = r_b;
            CMD_CMOV: begin
                n_res = r_b;
                n_we  = w_cond;
            end
            CMD_CMP, CMD_TEST: begin
                n_we    = 1'b0;
                n_less  = w_ca < w_cb;
                n_equal = w_ca == w_cb;
            end
            CMD_SET:   n_res = t_word'(w_cond);
            CMD_LNOT:  n_res = t_word'(r_a == '0);
            CMD_BNOT:  n_res = ~r_a;
            CMD_NEG:   n_res = (t_word'(0) - r_a) & w_m;
            CMD_ADD:   n_res = (r_a + r_b) & w_m;
            CMD_SUB:   n_res = (r_a - r_b) & w_m;
            CMD_MUL:   w_iter = 1'b1;
            CMD_DIV, CMD_REM: begin
                if (w_y == '0) begin
                    n_dz  = 1'b1;
                    n_res = (r_cmd == CMD_DIV) ? w_m : w_x;
                end else begin
                    w_iter = 1'b1;
                end
            end
            CMD_SHL:   n_res = (r_a << w_sh) & w_m;
            CMD_LSHR:  n_res = w_x >> w_sh;
            CMD_ASHR:  n_res = t_word'($signed(w_xs) >>> w_sh) & w_m;
            CMD_AND:   n_res = r_a & r_b & w_m;
            CMD_OR:    n_res = (r_a | r_b) & w_m;
            CMD_XOR:   n_res = (r_a ^ r_b) & w_m;
            CMD_SEXT1: n_res = {REG_BITS{r_a[0]}};
            CMD_SEXT:  n_res = f_sext(r_a, r_wc);
            default:   n_we = 1'b0;
        endcase

        w_ctl.start  = (r_state == S_EXEC) && w_iter;
        w_ctl.is_div = r_cmd != CMD_MUL;
        w_ctl.wide   = r_wce == WC_64;
    end

    vmieu_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_x     ((r_cmd == CMD_MUL) ? w_x : w_ux),
        .i_y     ((r_cmd == CMD_MUL) ? w_y : w_uy),
        .o_sts   (w_sts),
        .o_lo    (w_lo),
        .o_rem   (w_rem)
    );

    always_comb begin
        priority if (r_cmd == CMD_MUL) begin
            w_post = w_lo & w_m;
        end else if (r_cmd == CMD_DIV) begin
            w_post = (r_qneg ? (t_word'(0) - w_lo) : w_lo) & w_m;
        end else begin
            w_post = (r_xn ? (t_word'(0) - w_rem) : w_rem) & w_m;
        end
        w_out_free = !r_o_valid || o_res.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_less    <= 1'b0;
            r_equal   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_cmd.valid) r_state <= S_RDA;
                S_RDA:  r_state <= S_RDB;
                S_RDB:  r_state <= S_EXEC;
                S_EXEC: begin
                    r_less  <= n_less;
                    r_equal <= n_equal;
                    r_state <= w_iter ? S_ITER : S_DONE;
                end
                S_ITER: if (w_sts.done) r_state <= S_POST;
                S_POST: r_state <= S_DONE;
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cmd     <= i_cmd.command;
                r_wc      <= i_cmd.width_code;
                r_wce     <= (i_cmd.command >= CMD_ADD && i_cmd.command <= CMD_XOR
                              && i_cmd.width_code < WC_32) ? WC_32 : i_cmd.width_code;
                r_sgn     <= i_cmd.is_signed;
                r_use_imm <= i_cmd.use_immediate;
                r_cond    <= i_cmd.condition;
                r_d       <= w_idx_tab[i_cmd.dest_reg];
                r_s       <= w_idx_tab[i_cmd.src_reg];
                r_imm     <= i_cmd.immediate;
            end
            S_RDA:  r_a <= r_rdv ? r_rd : '0;
            S_RDB:  r_b <= r_use_imm ? r_imm : (r_rdv ? r_rd : '0);
            S_EXEC: begin
                r_res  <= n_res;
                r_we   <= n_we;
                r_dz   <= n_dz;
                r_xn   <= n_xn;
                r_qneg <= n_qneg;
            end
            S_POST: r_res <= w_post;
            S_DONE: begin
                if (w_out_free) begin
                    r_o_we    <= r_we;
                    r_o_reg   <= r_we ? RIDX_W'(r_d) : '0;
                    r_o_val   <= r_we ? r_res : '0;
                    r_o_less  <= r_less;
                    r_o_equal <= r_equal;
                    r_o_dz    <= r_dz;
                end
            end
            default: ;
        endcase
    end

    assign i_cmd.ready          = r_state == S_IDLE;
    assign o_res.valid          = r_o_valid;
    assign o_res.wrote_reg      = r_o_we;
    assign o_res.written_reg    = r_o_reg;
    assign o_res.written_value  = r_o_val;
    assign o_res.less_flag      = r_o_less;
    assign o_res.equal_flag     = r_o_equal;
    assign o_res.divide_by_zero = r_o_dz;

    a_dz_writes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.divide_by_zero |-> o_res.wrote_reg)
        else $error("divide by zero without a write");
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.wrote_reg |-> o_res.written_value == '0
        && o_res.written_reg == '0)
        else $error("non-zero payload on an item without a write");
    a_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> r_state == S_ITER)
        else $error("mul/div completion outside the iterate state");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("second item accepted while busy");
endmodule
